// ===== rtl/bifb_pkg.sv =====
// shared types and constants of the boot information framebuffer tag finder
package bifb_pkg;

    // one word of the boot information block
    typedef struct packed {
        logic [31:0] word;
        logic        first;
    } t_in_item;

    // one search result
    typedef struct packed {
        logic        status;
        logic [63:0] fb_address;
        logic [31:0] fb_pitch;
        logic [31:0] fb_width;
        logic [31:0] fb_height;
        logic [7:0]  fb_bpp;
        logic [7:0]  fb_kind;
    } t_out_item;

    localparam logic        STATUS_FOUND     = 1'b0;
    localparam logic        STATUS_NOT_FOUND = 1'b1;

    localparam logic [31:0] FB_TAG_TYPE    = 32'd8;
    localparam logic [31:0] MIN_BLOCK_SIZE = 32'd8;
    localparam logic [31:0] ALIGN_ADD      = 32'd7;
    localparam logic [31:0] ALIGN_MASK     = ~32'd7;

    localparam logic [32:0] WORD_BYTES     = 33'd4;
    localparam logic [32:0] FIRST_TAG_OFS  = 33'd8;

    // framebuffer tag field offsets relative to the tag start
    localparam logic [32:0] REL_ADDR_LO = 33'd8;
    localparam logic [32:0] REL_ADDR_HI = 33'd12;
    localparam logic [32:0] REL_PITCH   = 33'd16;
    localparam logic [32:0] REL_WIDTH   = 33'd20;
    localparam logic [32:0] REL_HEIGHT  = 33'd24;
    localparam logic [32:0] REL_BPP     = 33'd28;

endpackage

// ===== rtl/boot_info_framebuffer_tag_finder_unit.sv =====
// top level of the boot information framebuffer tag finder
//
// usage:
//   the input channel (i_in_valid / o_in_ready / i_in_data) takes the boot
//   information block one 32-bit little-endian word per request; first = 1
//   marks word 0, the total size, and restarts the search at any time
//   the output channel (o_out_valid / i_out_ready / o_out_data) returns at
//   most one result per block: found with the framebuffer fields, or not
//   found with all fields zero
// throughput and timing:
//   one word per cycle while no result waits; every word is parsed in the
//   cycle it is accepted, so a result is registered in the cycle after its
//   last word (framebuffer bpp, end tag, zero advance, block end, short block)
// stall:
//   the output register parts the channels; while it holds a result the
//   block still takes words when the receiver takes the result in the same
//   cycle, and stops taking words only while the result waits
// reset:
//   synchronous active-low i_rst_n returns to idle, drops any pending result
//   and ignores words until the next first word
module boot_info_framebuffer_tag_finder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bifb_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bifb_pkg::t_out_item  o_out_data
);
    import bifb_pkg::*;

    // parser phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_TYPE,
        PH_SIZE,
        PH_SKIP,
        PH_FB,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [32:0] r_byte_ofs, n_byte_ofs;       // offset of the incoming word
    logic [31:0] r_block_total, n_block_total;
    logic [32:0] r_tag_start, n_tag_start;
    logic [32:0] r_next_tag, n_next_tag;
    logic        r_kind_zero, n_kind_zero;     // current tag type is the end type
    logic [31:0] r_addr_lo, n_addr_lo;
    logic [31:0] r_addr_hi, n_addr_hi;
    logic [31:0] r_pitch, n_pitch;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;

    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        accept;
    logic        emit;
    t_out_item   n_out_data;

    t_phase      eff_phase;       // phase after a skip reaches the next tag
    logic [32:0] eff_tag_start;
    logic [31:0] aligned;
    logic [32:0] size_next;
    logic [32:0] rel;
    logic [31:0] w;

    // the output register frees up when empty or when it is taken now
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w = i_in_data.word;

    // skipping ends on the type word of the next tag
    always_comb begin
        if (r_phase == PH_SKIP && r_byte_ofs == r_next_tag) begin
            eff_phase     = PH_TYPE;
            eff_tag_start = r_next_tag;
        end else begin
            eff_phase     = r_phase;
            eff_tag_start = r_tag_start;
        end
    end

    // tag size rounded up to 8 with 32-bit wrap, added to the tag start
    assign aligned   = (w + ALIGN_ADD) & ALIGN_MASK;
    assign size_next = eff_tag_start + {1'b0, aligned};
    assign rel       = r_byte_ofs - eff_tag_start;

    always_comb begin
        n_phase       = r_phase;
        n_byte_ofs    = r_byte_ofs;
        n_block_total = r_block_total;
        n_tag_start   = r_tag_start;
        n_next_tag    = r_next_tag;
        n_kind_zero   = r_kind_zero;
        n_addr_lo     = r_addr_lo;
        n_addr_hi     = r_addr_hi;
        n_pitch       = r_pitch;
        n_width       = r_width;
        n_height      = r_height;
        emit          = 1'b0;
        n_out_data    = '0;
        n_out_data.status = STATUS_NOT_FOUND;

        if (accept) begin
            if (i_in_data.first) begin
                // new block: word 0 is the total size
                n_block_total = w;
                n_byte_ofs    = WORD_BYTES;
                n_tag_start   = FIRST_TAG_OFS;
                if (w <= MIN_BLOCK_SIZE) begin
                    emit    = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_HDR;
                end
            end else begin
                n_tag_start = eff_tag_start;
                unique case (eff_phase)
                    PH_HDR: begin
                        n_phase    = PH_TYPE;
                        n_byte_ofs = r_byte_ofs + WORD_BYTES;
                    end
                    PH_TYPE: begin
                        n_kind_zero = (w == '0);
                        n_phase     = (w == FB_TAG_TYPE) ? PH_FB : PH_SIZE;
                        n_byte_ofs  = r_byte_ofs + WORD_BYTES;
                    end
                    PH_SIZE: begin
                        // end tag, zero advance or block end all stop the search
                        if ((r_kind_zero && w == '0) || aligned == '0 ||
                            size_next >= {1'b0, r_block_total}) begin
                            emit    = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_next_tag = size_next;
                            n_phase    = PH_SKIP;
                            n_byte_ofs = r_byte_ofs + WORD_BYTES;
                        end
                    end
                    PH_SKIP: begin
                        n_byte_ofs = r_byte_ofs + WORD_BYTES;
                    end
                    PH_FB: begin
                        n_byte_ofs = r_byte_ofs + WORD_BYTES;
                        if (rel == REL_ADDR_LO) begin
                            n_addr_lo = w;
                        end else if (rel == REL_ADDR_HI) begin
                            n_addr_hi = w;
                        end else if (rel == REL_PITCH) begin
                            n_pitch = w;
                        end else if (rel == REL_WIDTH) begin
                            n_width = w;
                        end else if (rel == REL_HEIGHT) begin
                            n_height = w;
                        end else if (rel == REL_BPP) begin
                            // last field word completes the framebuffer result
                            emit                  = 1'b1;
                            n_phase               = PH_DONE;
                            n_byte_ofs            = r_byte_ofs;
                            n_out_data.status     = STATUS_FOUND;
                            n_out_data.fb_address = {r_addr_hi, r_addr_lo};
                            n_out_data.fb_pitch   = r_pitch;
                            n_out_data.fb_width   = r_width;
                            n_out_data.fb_height  = r_height;
                            n_out_data.fb_bpp     = w[7:0];
                            n_out_data.fb_kind    = w[15:8];
                        end
                    end
                    default: begin
                        // idle or done: words outside a block are dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_byte_ofs    <= '0;
            r_block_total <= '0;
            r_tag_start   <= '0;
            r_next_tag    <= '0;
            r_kind_zero   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_byte_ofs    <= n_byte_ofs;
            r_block_total <= n_block_total;
            r_tag_start   <= n_tag_start;
            r_next_tag    <= n_next_tag;
            r_kind_zero   <= n_kind_zero;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload holds, no reset
    always_ff @(posedge i_clk) begin
        r_addr_lo <= n_addr_lo;
        r_addr_hi <= n_addr_hi;
        r_pitch   <= n_pitch;
        r_width   <= n_width;
        r_height  <= n_height;
        if (emit) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
